// ===== rtl/core/polygon_affine_transform_defines.svh =====
// assertion macros for the polygon affine transform
`ifndef POLYGON_AFFINE_TRANSFORM_DEFINES_SVH
`define POLYGON_AFFINE_TRANSFORM_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication failed");

// next-cycle implication, checked outside reset
`define PAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== rtl/core/pat_pkg.sv =====
// types, constants and arithmetic helpers of the polygon affine transform
package pat_pkg;

  localparam int unsigned MaxResults  = 8;
  localparam int unsigned CordicSteps = 20;
  localparam logic signed [33:0] CordicK = 34'sd652032874;
  localparam logic signed [33:0] OneQ30  = 34'sd1073741824;

  typedef enum logic [2:0] {
    OP_LOAD      = 3'd0,
    OP_TRANSLATE = 3'd1,
    OP_ROTATE    = 3'd2,
    OP_SCALE     = 3'd3,
    OP_SHEAR     = 3'd4,
    OP_REFLECT_X = 3'd5,
    OP_REFLECT_Y = 3'd6,
    OP_UNUSED    = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CORDIC, ST_QUAD, ST_READ, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3,
    ST_FIN, ST_OUT
  } state_e;

  // arctangent of 2^-k in q16.16 degrees
  function automatic logic signed [24:0] atan_deg(input logic [4:0] k);
    logic signed [24:0] v;
    unique case (k)
      5'd0:  v = 25'sd2949120;
      5'd1:  v = 25'sd1740967;
      5'd2:  v = 25'sd919879;
      5'd3:  v = 25'sd466945;
      5'd4:  v = 25'sd234379;
      5'd5:  v = 25'sd117304;
      5'd6:  v = 25'sd58666;
      5'd7:  v = 25'sd29335;
      5'd8:  v = 25'sd14668;
      5'd9:  v = 25'sd7334;
      5'd10: v = 25'sd3667;
      5'd11: v = 25'sd1833;
      5'd12: v = 25'sd917;
      5'd13: v = 25'sd458;
      5'd14: v = 25'sd229;
      5'd15: v = 25'sd115;
      5'd16: v = 25'sd57;
      5'd17: v = 25'sd29;
      5'd18: v = 25'sd14;
      5'd19: v = 25'sd7;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // round q32 product to q16 half up, saturate
  function automatic logic signed [31:0] rnd16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd32768) >>> 16;
    return sat32(t);
  endfunction

  // round q46 sum to q16 half up, saturate
  function automatic logic signed [31:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd536870912) >>> 30;
    return sat32(t);
  endfunction

endpackage

// ===== rtl/core/polygon_affine_transform.sv =====
// top level of the polygon affine transform with its vertex memory
// Holds up to eight vertices in signed q16.16 in one synchronous memory
// (x and y side by side, registered read port). A load transfer writes
// one vertex and gives no result; the unused opcode gives none either. Every
// other operation walks vertices 0 .. count-1 (count clamped to 1 .. depth):
// read, modify through one shared 32x32 multiplier, then write back while
// the result is offered; last_o marks the final vertex. No input is taken
// until the last result has transferred. Translate and reflect skip the
// multiplier; scale, shear and rotate use it. A stalled result holds the walk.
// Rotate first runs the 20-step iterative cordic (skipped when the angle is
// a whole quarter turn), then maps the quarter turn.
// Entries never loaded read as zero through per-entry valid bits.
`include "polygon_affine_transform_defines.svh"

module polygon_affine_transform #(
  parameter int unsigned MAX_VERTICES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic [2:0]         vertex_index_i,
  input  logic signed [31:0] load_x_i,
  input  logic signed [31:0] load_y_i,
  input  logic signed [31:0] amount_x_i,
  input  logic signed [31:0] amount_y_i,
  input  logic signed [9:0]  angle_deg_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         out_index_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic               last_o,
  // vertex count register
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i
);

  localparam int unsigned Depth = (MAX_VERTICES < pat_pkg::MaxResults) ?
                                  MAX_VERTICES : pat_pkg::MaxResults;
  localparam int unsigned AW = $clog2(Depth);

  pat_pkg::state_e state_q, state_d;
  pat_pkg::op_e    op_q;

  logic [3:0]    cnt_q;
  logic [AW-1:0] idx_q, last_q;
  logic signed [31:0] ax_q, ay_q;

  // vertex memory and per-entry valid bits
  logic [63:0]   mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [63:0]   rdata_q;
  logic          rvld_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic          mem_re;

  // cordic
  logic signed [33:0] cx_q, cy_q;
  logic signed [24:0] cz_q;
  logic [4:0]         k_q;
  logic [1:0]         quad_q;

  // arithmetic
  logic signed [63:0] prod_q, acc_q;
  logic signed [31:0] nx_q, ny_q;
  logic signed [31:0] ma, mb;
  logic signed [31:0] xv, yv, cv, sv;

  // angle reduction
  logic signed [10:0] ang_t;
  logic [8:0]         ang_a;
  logic [2:0]         quad_n;
  logic signed [9:0]  resid;
  logic               in_xfer, out_xfer, is_load;
  logic [3:0]         n_eff;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;
  assign is_load  = (pat_pkg::op_e'(op_i) == pat_pkg::OP_LOAD);

  assign xv = rvld_q ? rdata_q[63:32] : '0;
  assign yv = rvld_q ? rdata_q[31:0]  : '0;
  assign cv = cx_q[31:0];
  assign sv = cy_q[31:0];

  // angle mod 360, split into quarter turn and residue in [-45, 44]
  always_comb begin
    ang_t = (angle_deg_i < 0) ? 11'(angle_deg_i) + 11'sd720 : 11'(angle_deg_i);
    if (ang_t >= 11'sd360) ang_t = ang_t - 11'sd360;
    ang_a = ang_t[8:0];
    if (ang_a < 9'd45)       quad_n = 3'd0;
    else if (ang_a < 9'd135) quad_n = 3'd1;
    else if (ang_a < 9'd225) quad_n = 3'd2;
    else if (ang_a < 9'd315) quad_n = 3'd3;
    else                     quad_n = 3'd4;
    resid = 10'({1'b0, ang_a}) - 10'(quad_n) * 10'd90;
  end

  // clamp the active count to at least one, at most the store depth
  always_comb begin
    if (cnt_q == 4'd0)            n_eff = 4'd1;
    else if (cnt_q > 4'(Depth))   n_eff = 4'(Depth);
    else                          n_eff = cnt_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pat_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (op_i)
            pat_pkg::OP_LOAD:   state_d = pat_pkg::ST_IDLE;
            pat_pkg::OP_ROTATE: state_d = (resid == '0) ? pat_pkg::ST_QUAD
                                                        : pat_pkg::ST_CORDIC;
            pat_pkg::OP_UNUSED: state_d = pat_pkg::ST_IDLE;
            default:            state_d = pat_pkg::ST_READ;
          endcase
        end
      end
      pat_pkg::ST_CORDIC: begin
        if (k_q == 5'(pat_pkg::CordicSteps - 1)) state_d = pat_pkg::ST_QUAD;
      end
      pat_pkg::ST_QUAD: state_d = pat_pkg::ST_READ;
      pat_pkg::ST_READ: state_d = pat_pkg::ST_MUL0;
      pat_pkg::ST_MUL0: begin
        if (op_q == pat_pkg::OP_ROTATE || op_q == pat_pkg::OP_SCALE ||
            op_q == pat_pkg::OP_SHEAR) begin
          state_d = pat_pkg::ST_MUL1;
        end else begin
          state_d = pat_pkg::ST_OUT;
        end
      end
      pat_pkg::ST_MUL1: state_d = (op_q == pat_pkg::OP_SCALE) ? pat_pkg::ST_FIN
                                                              : pat_pkg::ST_MUL2;
      pat_pkg::ST_MUL2: state_d = (op_q == pat_pkg::OP_ROTATE) ? pat_pkg::ST_MUL3
                                                               : pat_pkg::ST_FIN;
      pat_pkg::ST_MUL3: state_d = pat_pkg::ST_FIN;
      pat_pkg::ST_FIN:  state_d = pat_pkg::ST_OUT;
      pat_pkg::ST_OUT: begin
        if (!out_stall_i) state_d = (idx_q == last_q) ? pat_pkg::ST_IDLE
                                                      : pat_pkg::ST_READ;
      end
      default: state_d = pat_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    in_stall_o  = (state_q != pat_pkg::ST_IDLE);
    out_valid_o = (state_q == pat_pkg::ST_OUT);
    out_index_o = 3'(idx_q);
    out_x_o     = nx_q;
    out_y_o     = ny_q;
    last_o      = (idx_q == last_q);
    mem_re      = (state_q == pat_pkg::ST_READ);
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = {nx_q, ny_q};
    if (state_q == pat_pkg::ST_OUT) begin
      // write-back repeats while stalled, same data each cycle
      mem_we = 1'b1;
    end else if (state_q == pat_pkg::ST_IDLE && in_valid_i && is_load &&
                 32'(vertex_index_i) < Depth) begin
      mem_we    = 1'b1;
      mem_waddr = vertex_index_i[AW-1:0];
      mem_wdata = {load_x_i, load_y_i};
    end
  end

  // multiplier operand select
  always_comb begin
    ma = xv;
    mb = cv;
    unique case (state_q)
      pat_pkg::ST_MUL0: begin
        if (op_q == pat_pkg::OP_SCALE)      begin ma = xv;   mb = ax_q; end
        else if (op_q == pat_pkg::OP_SHEAR) begin ma = ax_q; mb = yv;   end
        else                                begin ma = xv;   mb = cv;   end
      end
      pat_pkg::ST_MUL1: begin
        if (op_q == pat_pkg::OP_SCALE) begin ma = yv; mb = ay_q; end
        else                           begin ma = yv; mb = sv;   end
      end
      pat_pkg::ST_MUL2: begin
        if (op_q == pat_pkg::OP_SHEAR) begin ma = ay_q; mb = nx_q; end
        else                           begin ma = xv;   mb = sv;   end
      end
      pat_pkg::ST_MUL3: begin
        ma = yv;
        mb = cv;
      end
      default: begin
        ma = xv;
        mb = cv;
      end
    endcase
  end

  // vertex memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) begin
      rdata_q <= mem[idx_q];
      rvld_q  <= vld_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[mem_waddr] <= 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pat_pkg::ST_IDLE;
      cnt_q   <= 4'd3;
      idx_q   <= '0;
      last_q  <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cnt_q <= cfg_wdata_i;
      if (in_xfer) begin
        idx_q  <= '0;
        last_q <= AW'(n_eff - 4'd1);
        k_q    <= '0;
      end
      if (state_q == pat_pkg::ST_CORDIC) k_q <= k_q + 5'd1;
      if (out_xfer && idx_q != last_q) idx_q <= idx_q + 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    if (in_xfer) begin
      op_q   <= pat_pkg::op_e'(op_i);
      ax_q   <= amount_x_i;
      ay_q   <= amount_y_i;
      quad_q <= quad_n[1:0];
      if (resid == '0) begin
        cx_q <= pat_pkg::OneQ30;
        cy_q <= '0;
      end else begin
        cx_q <= pat_pkg::CordicK;
        cy_q <= '0;
        cz_q <= 25'(resid) <<< 16;
      end
    end
    unique case (state_q)
      pat_pkg::ST_CORDIC: begin
        // rotate toward zero residual angle
        if (cz_q >= 0) begin
          cx_q <= cx_q - (cy_q >>> k_q);
          cy_q <= cy_q + (cx_q >>> k_q);
          cz_q <= cz_q - pat_pkg::atan_deg(k_q);
        end else begin
          cx_q <= cx_q + (cy_q >>> k_q);
          cy_q <= cy_q - (cx_q >>> k_q);
          cz_q <= cz_q + pat_pkg::atan_deg(k_q);
        end
      end
      pat_pkg::ST_QUAD: begin
        // exact quarter-turn mapping of cos and sin
        unique case (quad_q)
          2'd1: begin cx_q <= -cy_q; cy_q <= cx_q;  end
          2'd2: begin cx_q <= -cx_q; cy_q <= -cy_q; end
          2'd3: begin cx_q <= cy_q;  cy_q <= -cx_q; end
          default: begin cx_q <= cx_q; cy_q <= cy_q; end
        endcase
      end
      pat_pkg::ST_MUL0: begin
        nx_q <= xv;
        ny_q <= yv;
        unique case (op_q)
          pat_pkg::OP_TRANSLATE: begin
            nx_q <= pat_pkg::sat32(64'(xv) + 64'(ax_q));
            ny_q <= pat_pkg::sat32(64'(yv) + 64'(ay_q));
          end
          pat_pkg::OP_REFLECT_X: ny_q <= pat_pkg::sat32(-64'(yv));
          pat_pkg::OP_REFLECT_Y: nx_q <= pat_pkg::sat32(-64'(xv));
          default: ;
        endcase
      end
      pat_pkg::ST_MUL1: begin
        unique case (op_q)
          pat_pkg::OP_SCALE: nx_q <= pat_pkg::rnd16(prod_q);
          pat_pkg::OP_SHEAR:
            nx_q <= pat_pkg::sat32(64'(xv) + 64'(pat_pkg::rnd16(prod_q)));
          default: acc_q <= prod_q;
        endcase
      end
      pat_pkg::ST_MUL2: begin
        if (op_q == pat_pkg::OP_ROTATE) nx_q <= pat_pkg::rnd30(acc_q - prod_q);
      end
      pat_pkg::ST_MUL3: acc_q <= prod_q;
      pat_pkg::ST_FIN: begin
        unique case (op_q)
          pat_pkg::OP_SCALE: ny_q <= pat_pkg::rnd16(prod_q);
          pat_pkg::OP_SHEAR:
            ny_q <= pat_pkg::sat32(64'(yv) + 64'(pat_pkg::rnd16(prod_q)));
          default: ny_q <= pat_pkg::rnd30(acc_q + prod_q);
        endcase
      end
      default: ;
    endcase
  end

  // no new item while a result is pending
  `PAT_ASSERT_NOW(a_no_take_while_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  // a non-final transfer moves on to the next vertex read
  `PAT_ASSERT_NEXT(a_walk_next, clk_i, rst_ni, out_xfer && !last_o,
                   state_q == pat_pkg::ST_READ)
  // the final transfer returns to idle
  `PAT_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, out_xfer && last_o,
                   state_q == pat_pkg::ST_IDLE)

endmodule

// ===== verif/tb_polygon_affine_transform.sv =====
// testbench for the polygon affine transform: directed and random transfers
`timescale 1ns / 1ps

module tb_polygon_affine_transform;

  localparam int NumVert = 8;
  localparam int WatchLimit = 20000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         op_i;
  logic [2:0]         vertex_index_i;
  logic signed [31:0] load_x_i;
  logic signed [31:0] load_y_i;
  logic signed [31:0] amount_x_i;
  logic signed [31:0] amount_y_i;
  logic signed [9:0]  angle_deg_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [2:0]         out_index_o;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic               last_o;
  logic               cfg_we_i;
  logic [3:0]         cfg_wdata_i;

  typedef struct packed {
    logic [2:0]         index;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
  } vertex_res_t;

  // predictor state: shadow copy of the vertex memory and count register
  logic signed [31:0] shadow_x [NumVert];
  logic signed [31:0] shadow_y [NumVert];
  logic [3:0]         shadow_count;
  vertex_res_t        expected_vertices [$];

  int mismatch_count;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  // the device under test
  polygon_affine_transform #(.MAX_VERTICES(NumVert)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .vertex_index_i (vertex_index_i),
    .load_x_i       (load_x_i),
    .load_y_i       (load_y_i),
    .amount_x_i     (amount_x_i),
    .amount_y_i     (amount_y_i),
    .angle_deg_i    (angle_deg_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_index_o    (out_index_o),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- arithmetic

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // q16 product, round half up, saturate
  function automatic logic signed [31:0] fix_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b);
    return clamp32((p + 66'sd32768) >>> 16);
  endfunction

  function automatic logic signed [31:0] atan_q16(input int k);
    int tbl [20] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                     29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                     29, 14, 7};
    return tbl[k];
  endfunction

  // cosine and sine in q2.30 for a whole-degree angle
  task automatic angle_to_cos_sin(input int deg, output longint c, output longint s);
    int a, q, r;
    longint x, y, z, dx, dy, cc, ss;
    a = deg % 360;
    if (a < 0) a += 360;
    q = (a + 45) / 90;
    r = a - q * 90;
    q = q & 3;
    if (r == 0) begin
      cc = 64'sd1073741824;
      ss = 0;
    end else begin
      x = 64'sd652032874;
      y = 0;
      z = longint'(r) * 65536;
      for (int i = 0; i < 20; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_q16(i);
        end else begin
          x += dx; y -= dy; z += atan_q16(i);
        end
      end
      cc = x;
      ss = y;
    end
    case (q)
      1: begin c = -ss; s = cc; end
      2: begin c = -cc; s = -ss; end
      3: begin c = ss; s = -cc; end
      default: begin c = cc; s = ss; end
    endcase
  endtask

  function automatic bit op_i_is_unused(input logic [2:0] op);
    return op > pat_pkg::OP_REFLECT_Y;
  endfunction

  // apply one transfer to the shadow polygon and queue the emitted vertices
  task automatic predict_polygon(input pat_pkg::op_e op, input logic [2:0] vi,
                                 input logic signed [31:0] lx, ly, ax, ay,
                                 input logic signed [9:0] ang);
    int n;
    longint c, s;
    logic signed [31:0] x, y, nx, ny;
    logic signed [65:0] acc;
    vertex_res_t r;
    if (op == pat_pkg::OP_LOAD) begin
      shadow_x[vi] = lx;
      shadow_y[vi] = ly;
      return;
    end
    if (op_i_is_unused(op)) return;
    n = shadow_count;
    if (n < 1) n = 1;
    if (n > NumVert) n = NumVert;
    c = 64'sd1073741824;
    s = 0;
    if (op == pat_pkg::OP_ROTATE) angle_to_cos_sin(int'(ang), c, s);
    for (int i = 0; i < n; i++) begin
      x = shadow_x[i];
      y = shadow_y[i];
      nx = x;
      ny = y;
      case (op)
        pat_pkg::OP_TRANSLATE: begin
          nx = clamp32(66'(x) + 66'(ax));
          ny = clamp32(66'(y) + 66'(ay));
        end
        pat_pkg::OP_ROTATE: begin
          acc = 66'(x) * 66'(c) - 66'(y) * 66'(s) + 66'sd536870912;
          nx = clamp32(acc >>> 30);
          acc = 66'(x) * 66'(s) + 66'(y) * 66'(c) + 66'sd536870912;
          ny = clamp32(acc >>> 30);
        end
        pat_pkg::OP_SCALE: begin
          nx = fix_mul(x, ax);
          ny = fix_mul(y, ay);
        end
        pat_pkg::OP_SHEAR: begin
          // y uses the freshly sheared x
          nx = clamp32(66'(x) + 66'(fix_mul(ax, y)));
          ny = clamp32(66'(y) + 66'(fix_mul(ay, nx)));
        end
        pat_pkg::OP_REFLECT_X: ny = clamp32(-66'(y));
        default:               nx = clamp32(-66'(x));
      endcase
      shadow_x[i] = nx;
      shadow_y[i] = ny;
      r.index = 3'(i);
      r.x = nx;
      r.y = ny;
      r.last = (i + 1 == n);
      expected_vertices.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  task automatic send_item(input logic [2:0] op, input logic [2:0] vi,
                           input logic signed [31:0] lx, ly, ax, ay,
                           input logic signed [9:0] ang);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    vertex_index_i <= vi;
    load_x_i       <= lx;
    load_y_i       <= ly;
    amount_x_i     <= ax;
    amount_y_i     <= ay;
    angle_deg_i    <= ang;
    do @(posedge clk_i); while (in_stall_o);
    predict_polygon(pat_pkg::op_e'(op), vi, lx, ly, ax, ay, ang);
    @(negedge clk_i);
  endtask

  // wait for all results, then let the block settle before a register write
  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (expected_vertices.size() != 0 && guard < WatchLimit) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (60) @(negedge clk_i);
  endtask

  task automatic set_vertex_count(input logic [3:0] n);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_count = n;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(400000))) - 32'sd200000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_factor();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'sh00010000;
      default: return 32'($signed($urandom_range(262144))) - 32'sd131072;
    endcase
  endfunction

  task automatic send_random(input bit loads_only);
    logic [2:0] op;
    logic signed [9:0] ang;
    op = loads_only ? pat_pkg::OP_LOAD : 3'($urandom_range(7));
    ang = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(720)) - 10'sd360;
    send_item(op, 3'($urandom), rand_coord(), rand_coord(), rand_factor(),
              rand_factor(), ang);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    send_item(pat_pkg::OP_TRANSLATE, 3'd0, 0, 0, 32'sh00010000, -32'sh00020000, 10'sd0);
    send_item(pat_pkg::OP_LOAD, 3'd0, 32'sh7fffffff, 32'sh80000000, 0, 0, 10'sd0);
    send_item(pat_pkg::OP_LOAD, 3'd1, 32'sh00030000, -32'sh00018000, 0, 0, 10'sd0);
    send_item(pat_pkg::OP_LOAD, 3'd7, 32'sh80000000, 32'sh7fffffff, 0, 0, 10'sd0);
    send_item(pat_pkg::OP_TRANSLATE, 3'd0, 0, 0, 32'sh7fffffff, 32'sh80000000, 10'sd0);
    send_item(pat_pkg::OP_REFLECT_X, 3'd0, 0, 0, 0, 0, 10'sd0);
    send_item(pat_pkg::OP_REFLECT_Y, 3'd0, 0, 0, 0, 0, 10'sd0);
    // unused opcode gives nothing
    send_item(pat_pkg::OP_UNUSED, 3'd0, 0, 0, 0, 0, 10'sd0);
    send_item(pat_pkg::OP_LOAD, 3'd0, 32'sh00050000, 32'sh00020000, 0, 0, 10'sd0);
    send_item(pat_pkg::OP_ROTATE, 3'd0, 0, 0, 0, 0, 10'sd90);
    send_item(pat_pkg::OP_ROTATE, 3'd0, 0, 0, 0, 0, 10'sd30);
    send_item(pat_pkg::OP_ROTATE, 3'd0, 0, 0, 0, 0, -10'sd360);
    send_item(pat_pkg::OP_ROTATE, 3'd0, 0, 0, 0, 0, 10'sh1ff);
    send_item(pat_pkg::OP_ROTATE, 3'd0, 0, 0, 0, 0, 10'sh200);
    send_item(pat_pkg::OP_ROTATE, 3'd0, 0, 0, 0, 0, 10'sd45);
    send_item(pat_pkg::OP_SCALE, 3'd0, 0, 0, 32'sh00020000, 32'sh80000000, 10'sd0);
    send_item(pat_pkg::OP_SCALE, 3'd0, 0, 0, 32'sh7fffffff, 32'sh00008000, 10'sd0);
    send_item(pat_pkg::OP_SHEAR, 3'd0, 0, 0, 32'sh00010000, -32'sh00008000, 10'sd0);
    send_item(pat_pkg::OP_SHEAR, 3'd0, 0, 0, 32'sh80000000, 32'sh7fffffff, 10'sd0);
  endtask

  task automatic test_vertex_counts();
    logic [3:0] counts [5] = '{4'd0, 4'd15, 4'd8, 4'd1, 4'd5};
    foreach (counts[k]) begin
      set_vertex_count(counts[k]);
      send_random(1'b0);
      send_item(pat_pkg::OP_REFLECT_Y, 3'd0, 0, 0, 0, 0, 10'sd0);
    end
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int items);
    idle_pct  = idle;
    stall_pct = stall;
    set_vertex_count(4'($urandom_range(15)));
    for (int i = 0; i < 8; i++) send_random(1'b1);
    for (int i = 0; i < items; i++) send_random($urandom_range(3) == 0);
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    vertex_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_vertices.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_vertices.pop_front();
        if (out_index_o !== want.index) report_mismatch("out_index");
        if (out_x_o !== want.x)
          report_mismatch($sformatf("out_x %h want %h", out_x_o, want.x));
        if (out_y_o !== want.y)
          report_mismatch($sformatf("out_y %h want %h", out_y_o, want.y));
        if (last_o !== want.last) report_mismatch("last");
      end
    end
  end

  // receiver stall, redrawn every cycle
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles without any transfer while an item or result is pending
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i
        || (expected_vertices.size() == 0 && !in_valid_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    quiet_cycles   = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    shadow_count   = 4'd3;
    for (int i = 0; i < NumVert; i++) begin
      shadow_x[i] = '0;
      shadow_y[i] = '0;
    end
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_stall_i    = 1'b0;
    op_i           = '0;
    vertex_index_i = '0;
    load_x_i       = '0;
    load_y_i       = '0;
    amount_x_i     = '0;
    amount_y_i     = '0;
    angle_deg_i    = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_vertex_counts();
    test_random_phase(0, 0, 52);
    test_random_phase(60, 0, 52);
    test_random_phase(0, 60, 52);
    test_random_phase(8, 8, 52);
    drain_results();

    if (mismatch_count == 0 && expected_vertices.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pat_pkg.sv
rtl/core/polygon_affine_transform.sv
verif/tb_polygon_affine_transform.sv
